@@ src/hlt_pkg.sv @@
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and constants for the Huffman lookup table builder.
// ----------------------------------------------------------------------------
package hlt_pkg;

    // Item kinds on the table definition channel
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_COUNT  = 2'd1;
    localparam logic [1:0] KIND_SYMBOL = 2'd2;

    // Configuration register indexes
    localparam logic REG_PROGRESSIVE = 1'b0;
    localparam logic REG_THUMBNAIL   = 1'b1;
    localparam int   APB_ADDR_W      = 3;

    localparam int         NUM_LENGTHS   = 16;
    localparam logic [4:0] MAX_CODE_LEN  = 5'd16;
    localparam logic [4:0] DC_MAX_LEN    = 5'd12;
    localparam logic [4:0] DC_SHORT_BITS = 5'd6;
    localparam logic [4:0] AC_SHORT_BITS = 5'd10;
    localparam logic [4:0] DC_LONG_BITS  = 5'd12;
    localparam logic [4:0] AC_LONG_BITS  = 5'd16;
    localparam logic [4:0] DC_PREFIX_LEN = 5'd5;
    localparam logic [4:0] AC_PREFIX_LEN = 5'd6;
    localparam logic [16:0] DC_PREFIX    = 17'h1f;
    localparam logic [16:0] AC_PREFIX    = 17'h3f;
    localparam logic [9:0] DC_LONG_MASK  = 10'h07f;
    localparam logic [9:0] AC_LONG_MASK  = 10'h3ff;
    localparam logic [8:0] DC_RUN_LIMIT  = 9'd6;
    localparam logic [9:0] COEFF_BASE    = 10'd512;

    typedef struct packed {
        logic progressive;
        logic thumbnail;
    } cfg_t;

    // Operands handed to the code mapping unit
    typedef struct packed {
        logic [16:0] code;
        logic [4:0]  len;
        logic [7:0]  sym;
        logic        ac;
        cfg_t        cfg;
    } map_req_t;

    typedef struct packed {
        logic        fail;
        logic        region;
        logic [9:0]  addr;
        logic [3:0]  count;
        logic [15:0] val;
        logic        run;
        logic [2:0]  mag;
        logic [3:0]  loop_exp;
    } map_rsp_t;

    typedef struct packed {
        logic        out_class;
        logic [1:0]  out_table;
        logic        region;
        logic [9:0]  start_address;
        logic [10:0] fill_length;
        logic [15:0] entry_value;
        logic        is_error;
        logic        last_of_run;
    } fill_item_t;

endpackage

@@ src/hlt_channels.sv @@
// ----------------------------------------------------------------------------
// hlt channels
// Valid/ready channels for table definition items and fill command items.
// ----------------------------------------------------------------------------
interface hlt_def_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       table_class;
    logic [1:0] table_number;
    logic [7:0] payload;

    modport source (output valid, kind, table_class, table_number, payload, input ready);
    modport sink   (input valid, kind, table_class, table_number, payload, output ready);
endinterface

interface hlt_fill_if;
    logic        valid;
    logic        ready;
    logic        out_class;
    logic [1:0]  out_table;
    logic        region;
    logic [9:0]  start_address;
    logic [10:0] fill_length;
    logic [15:0] entry_value;
    logic        is_error;
    logic        last_of_run;

    modport source (output valid, out_class, out_table, region, start_address,
                    fill_length, entry_value, is_error, last_of_run, input ready);
    modport sink   (input valid, out_class, out_table, region, start_address,
                    fill_length, entry_value, is_error, last_of_run, output ready);
endinterface

@@ src/huffman_lookup_table_builder_unit.sv @@
// ----------------------------------------------------------------------------
// huffman_lookup_table_builder_unit
// Builds canonical JPEG Huffman decode tables as range-fill commands.
// ----------------------------------------------------------------------------
// Start and count items are taken in the idle state. The sixteenth count then
// walks the bit lengths one per cycle to find the first code. A symbol item
// goes through the accepting step, one pass through the shared code mapping
// unit, the fill commands it issues, and a closing seek step. Up to 32
// coefficient runs come before the final fill, and each fill command is held
// back while the output register still waits on the sink. The seek then
// advances over each bit length whose codes are used up. A code that does not
// fit goes from the mapping step to a single error fill command. The input is
// not ready while a symbol or seek is in progress; a finished fill command
// waits in the output register without holding up the next item.
module huffman_lookup_table_builder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    hlt_def_if.sink                        tbl_def,
    hlt_fill_if.source                     fill_cmd,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hlt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import hlt_pkg::*;

    cfg_t     cfg;
    map_req_t map_req;
    map_rsp_t map_rsp;

    hlt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hlt_code_map u_map (
        .req (map_req),
        .rsp (map_rsp)
    );

    hlt_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .tbl_def  (tbl_def),
        .fill_cmd (fill_cmd),
        .cfg      (cfg),
        .map_req  (map_req),
        .map_rsp  (map_rsp)
    );

endmodule

@@ src/hlt_apb_regs.sv @@
// ----------------------------------------------------------------------------
// hlt_apb_regs
// APB configuration registers: progressive and thumbnail mode bits.
// ----------------------------------------------------------------------------
module hlt_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hlt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output hlt_pkg::cfg_t                  cfg
);
    import hlt_pkg::*;

    logic progressive_reg;
    logic thumbnail_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progressive_reg <= 1'b0;
            thumbnail_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_PROGRESSIVE)
            begin
                progressive_reg <= pwdata[0];
            end
            if (paddr[2] == REG_THUMBNAIL)
            begin
                thumbnail_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_THUMBNAIL) ? {31'd0, thumbnail_reg}
                                                : {31'd0, progressive_reg};

    assign cfg.progressive = progressive_reg;
    assign cfg.thumbnail   = thumbnail_reg;

endmodule

@@ src/hlt_code_map.sv @@
// ----------------------------------------------------------------------------
// hlt_code_map
// Shared shift/compare unit: maps one canonical code to its region, start
// entry, fill size and entry value, and flags codes that do not fit.
// ----------------------------------------------------------------------------
module hlt_code_map (
    input  hlt_pkg::map_req_t req,
    output hlt_pkg::map_rsp_t rsp
);
    import hlt_pkg::*;

    logic        too_big;
    logic        dc_long;
    logic        ac_long;
    logic        is_long;
    logic [4:0]  base;
    logic [4:0]  count_w;
    logic [16:0] shifted;
    logic [8:0]  sym_len;
    logic [7:0]  dc_hi;
    logic [7:0]  thumb_hi;
    logic [4:0]  thumb_lo;
    logic        short_too_long;

    always_comb
    begin
        too_big = |(req.code >> req.len);
        dc_long = (req.len >= DC_PREFIX_LEN) &&
                  ((req.code >> (req.len - DC_PREFIX_LEN)) == DC_PREFIX);
        ac_long = (req.len >= AC_PREFIX_LEN) &&
                  ((req.code >> (req.len - AC_PREFIX_LEN)) == AC_PREFIX);
        is_long = req.ac ? ac_long : dc_long;

        if (req.ac)
        begin
            base = is_long ? AC_LONG_BITS : AC_SHORT_BITS;
        end
        else
        begin
            base = is_long ? DC_LONG_BITS : DC_SHORT_BITS;
        end
        count_w = base - req.len;

        short_too_long = !is_long &&
                         (req.len > (req.ac ? AC_SHORT_BITS : DC_SHORT_BITS));
        rsp.fail = too_big || (!req.ac && (req.len > DC_MAX_LEN)) || short_too_long;

        shifted    = req.code << count_w[3:0];
        rsp.region = is_long;
        rsp.count  = count_w[3:0];
        if (!is_long)
        begin
            rsp.addr = shifted[9:0];
        end
        else if (req.ac)
        begin
            rsp.addr = shifted[9:0] & AC_LONG_MASK;
        end
        else
        begin
            rsp.addr = shifted[9:0] & DC_LONG_MASK;
        end

        // DC magnitude coefficient runs for small symbols
        sym_len  = {1'b0, req.sym} + {4'd0, req.len};
        rsp.run  = !req.ac && (req.sym != 8'd0) && (sym_len <= DC_RUN_LIMIT) &&
                   !req.cfg.progressive;
        rsp.mag      = req.sym[2:0];
        rsp.loop_exp = count_w[3:0] - {1'b0, req.sym[2:0]};

        dc_hi    = rsp.run ? sym_len[7:0] : {3'd0, req.len};
        thumb_hi = {3'd0, req.len} + {4'd0, req.sym[3:0]};
        thumb_lo = {1'b0, req.sym[7:4]} + 5'd1;

        if (!req.ac)
        begin
            rsp.val = {8'd0, req.sym | {dc_hi[3:0], 4'd0}};
        end
        else if (req.cfg.thumbnail && (req.sym != 8'd0))
        begin
            rsp.val = {thumb_hi, 3'd0, thumb_lo};
        end
        else
        begin
            rsp.val = {3'd0, req.len, req.sym};
        end
    end

endmodule

@@ src/hlt_sequencer.sv @@
// ----------------------------------------------------------------------------
// hlt_sequencer
// Table state, code-length store and control sequence; drives the code
// mapping unit and holds the outgoing fill command item.
// ----------------------------------------------------------------------------
module hlt_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    hlt_def_if.sink           tbl_def,
    hlt_fill_if.source        fill_cmd,
    input  hlt_pkg::cfg_t     cfg,
    output hlt_pkg::map_req_t map_req,
    input  hlt_pkg::map_rsp_t map_rsp
);
    import hlt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SEEK  = 6'b000010,
        ST_MAP   = 6'b000100,
        ST_RUN   = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_FAIL  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  counts_reg [NUM_LENGTHS];
    logic [4:0]  loaded_reg, loaded_next;
    logic [4:0]  len_reg, len_next;
    logic [7:0]  left_reg, left_next;
    logic [16:0] code_reg, code_next;
    logic        class_reg, class_next;
    logic [1:0]  table_reg, table_next;
    logic        err_reg, err_next;
    logic [7:0]  sym_reg, sym_next;

    logic        region_reg, region_next;
    logic [9:0]  addr_reg, addr_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] val_reg, val_next;
    logic [2:0]  mag_reg, mag_next;
    logic [10:0] loop_reg, loop_next;
    logic [9:0]  run_addr_reg, run_addr_next;
    logic [4:0]  j_reg, j_next;

    logic        out_valid_reg, out_valid_next;
    fill_item_t  out_item_reg, out_item_next;

    logic        accept;
    logic        out_free;
    logic        count_wr;
    logic [4:0]  run_mask;
    logic        half_bit;
    logic [7:0]  coeff;

    assign tbl_def.ready = (state_reg == ST_IDLE);
    assign accept        = tbl_def.valid && tbl_def.ready;
    assign out_free      = !out_valid_reg || fill_cmd.ready;
    assign count_wr      = accept && (tbl_def.kind == KIND_COUNT) &&
                           (loaded_reg < 5'(NUM_LENGTHS));

    assign map_req.code = code_reg;
    assign map_req.len  = len_reg;
    assign map_req.sym  = sym_reg;
    assign map_req.ac   = class_reg;
    assign map_req.cfg  = cfg;

    // Run j holds j when its top magnitude bit is set, else j - (2^mag - 1)
    assign run_mask = 5'((6'd1 << mag_reg) - 6'd1);
    assign half_bit = j_reg[mag_reg - 3'd1];
    assign coeff    = half_bit ? {3'd0, j_reg} : ({3'd0, j_reg} - {3'd0, run_mask});

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        code_next      = code_reg;
        class_next     = class_reg;
        table_next     = table_reg;
        err_next       = err_reg;
        sym_next       = sym_reg;
        region_next    = region_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        val_next       = val_reg;
        mag_next       = mag_reg;
        loop_next      = loop_reg;
        run_addr_next  = run_addr_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !fill_cmd.ready;
        out_item_next  = out_item_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (tbl_def.kind)
                        KIND_START:
                        begin
                            class_next  = tbl_def.table_class;
                            table_next  = tbl_def.table_number;
                            loaded_next = 5'd0;
                            len_next    = 5'd1;
                            left_next   = 8'd0;
                            code_next   = 17'd0;
                            err_next    = 1'b0;
                        end
                        KIND_COUNT:
                        begin
                            if (count_wr)
                            begin
                                loaded_next = loaded_reg + 5'd1;
                                if (loaded_reg == 5'(NUM_LENGTHS - 1))
                                begin
                                    // first seek step steps to length 1
                                    len_next   = 5'd0;
                                    left_next  = 8'd0;
                                    code_next  = 17'd0;
                                    state_next = ST_SEEK;
                                end
                            end
                        end
                        KIND_SYMBOL:
                        begin
                            if ((loaded_reg == 5'(NUM_LENGTHS)) &&
                                (len_reg <= MAX_CODE_LEN) && !err_reg)
                            begin
                                sym_next   = tbl_def.payload;
                                state_next = ST_MAP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SEEK:
            begin
                if ((left_reg == 8'd0) && (len_reg <= MAX_CODE_LEN))
                begin
                    len_next  = len_reg + 5'd1;
                    code_next = {code_reg[15:0], 1'b0};
                    if (len_reg < MAX_CODE_LEN)
                    begin
                        left_next = counts_reg[len_reg[3:0]];
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_MAP:
            begin
                region_next   = map_rsp.region;
                addr_next     = map_rsp.addr;
                count_next    = map_rsp.count;
                val_next      = map_rsp.val;
                mag_next      = map_rsp.mag;
                loop_next     = 11'd1 << map_rsp.loop_exp;
                run_addr_next = COEFF_BASE + map_rsp.addr;
                j_next        = 5'd0;
                if (map_rsp.fail)
                begin
                    state_next = ST_FAIL;
                end
                else if (map_rsp.run)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.out_class     = class_reg;
                    out_item_next.out_table     = table_reg;
                    out_item_next.region        = region_reg;
                    out_item_next.start_address = run_addr_reg;
                    out_item_next.fill_length   = loop_reg;
                    out_item_next.entry_value   = {8'd0, coeff};
                    out_item_next.is_error      = 1'b0;
                    out_item_next.last_of_run   = 1'b0;
                    run_addr_next = run_addr_reg + loop_reg[9:0];
                    j_next        = j_reg + 5'd1;
                    if (j_reg == run_mask)
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.out_class     = class_reg;
                    out_item_next.out_table     = table_reg;
                    out_item_next.region        = region_reg;
                    out_item_next.start_address = addr_reg;
                    out_item_next.fill_length   = 11'd1 << count_reg;
                    out_item_next.entry_value   = val_reg;
                    out_item_next.is_error      = 1'b0;
                    out_item_next.last_of_run   = 1'b1;
                    left_next  = left_reg - 8'd1;
                    code_next  = code_reg + 17'd1;
                    state_next = ST_SEEK;
                end
            end

            ST_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.out_class     = class_reg;
                    out_item_next.out_table     = table_reg;
                    out_item_next.region        = 1'b0;
                    out_item_next.start_address = 10'd0;
                    out_item_next.fill_length   = 11'd0;
                    out_item_next.entry_value   = 16'd0;
                    out_item_next.is_error      = 1'b1;
                    out_item_next.last_of_run   = 1'b1;
                    err_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loaded_reg    <= 5'd0;
            len_reg       <= 5'd1;
            left_reg      <= 8'd0;
            code_reg      <= 17'd0;
            class_reg     <= 1'b0;
            table_reg     <= 2'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            len_reg       <= len_next;
            left_reg      <= left_next;
            code_reg      <= code_next;
            class_reg     <= class_next;
            table_reg     <= table_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_wr)
        begin
            counts_reg[loaded_reg[3:0]] <= tbl_def.payload;
        end
        sym_reg      <= sym_next;
        region_reg   <= region_next;
        addr_reg     <= addr_next;
        count_reg    <= count_next;
        val_reg      <= val_next;
        mag_reg      <= mag_next;
        loop_reg     <= loop_next;
        run_addr_reg <= run_addr_next;
        j_reg        <= j_next;
        out_item_reg <= out_item_next;
    end

    assign fill_cmd.valid         = out_valid_reg;
    assign fill_cmd.out_class     = out_item_reg.out_class;
    assign fill_cmd.out_table     = out_item_reg.out_table;
    assign fill_cmd.region        = out_item_reg.region;
    assign fill_cmd.start_address = out_item_reg.start_address;
    assign fill_cmd.fill_length   = out_item_reg.fill_length;
    assign fill_cmd.entry_value   = out_item_reg.entry_value;
    assign fill_cmd.is_error      = out_item_reg.is_error;
    assign fill_cmd.last_of_run   = out_item_reg.last_of_run;

endmodule
